@@ hw/rtl/bracket_balance_checker_macros.svh @@
// Assertion macros used by the bracket balance checker RTL.
`ifndef BRACKET_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracket balance checker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracket balance checker: next-cycle check failed");

`endif

@@ hw/rtl/bbc_pkg.sv @@
// Types, constants and character functions of the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_VALID     = 3'd1,
        ST_BADCHAR   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_MISMATCH  = 3'd5,
        ST_UNCLOSED  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OPEN_SQUARE = 2'd0,
        OPEN_CURLY  = 2'd1,
        OPEN_ANGLE  = 2'd2,
        NO_OPENER   = 2'd3
    } opener_t;

    typedef logic [DEPTH_W-1:0] depth_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } char_item_t;

    typedef struct packed {
        status_t    status;
        logic       line_done;
        logic [5:0] nest_depth;
    } result_item_t;

    // Shift commands for the stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

    function automatic logic char_allowed(logic [7:0] ch);
        logic ok;
        ok = 1'b0;
        if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
            (ch >= "0" && ch <= "9"))
        begin
            ok = 1'b1;
        end
        case (ch)
            "/", "*", "(", ")", ",", "<", ">", "{", "}", "[", "]",
            "~", "_", "-", " ":
            begin
                ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        return ok;
    endfunction

    function automatic opener_t opener_of(logic [7:0] ch);
        opener_t op;
        case (ch)
            "[":     op = OPEN_SQUARE;
            "{":     op = OPEN_CURLY;
            "<":     op = OPEN_ANGLE;
            default: op = NO_OPENER;
        endcase
        return op;
    endfunction

    function automatic opener_t closer_of(logic [7:0] ch);
        opener_t cl;
        case (ch)
            "]":     cl = OPEN_SQUARE;
            "}":     cl = OPEN_CURLY;
            ">":     cl = OPEN_ANGLE;
            default: cl = NO_OPENER;
        endcase
        return cl;
    endfunction

    // Saturate the stack depth into the six-bit display field
    function automatic logic [5:0] nest_of(depth_t d);
        logic [DEPTH_W+5:0] wide;
        wide = (DEPTH_W + 6)'(d);
        if (wide > (DEPTH_W + 6)'(63))
        begin
            return 6'd63;
        end
        return wide[5:0];
    endfunction

endpackage

@@ hw/rtl/bracket_balance_checker.sv @@
// Bracket balance checker: one result per character, one character per cycle while char_stall is low.
// The result of a character is registered and presented in the cycle after its transaction.
// Throughput: one character per cycle while char_stall is low; an opener or closer needs one shift of the cell chain.
// A result waiting under stall blocks a new character only while it is stalled.
// Reset clears the depth count, the sticky error and the result valid flag.
// Stack cells are not reset; only entries below the depth are ever read.
`include "bracket_balance_checker_macros.svh"

module bracket_balance_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  bbc_pkg::char_item_t   char_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output bbc_pkg::result_item_t result_data
);

    localparam bbc_pkg::depth_t FULL_DEPTH = bbc_pkg::depth_t'(bbc_pkg::STACK_DEPTH);

    bbc_pkg::depth_t       depth_reg, depth_next;
    bbc_pkg::status_t      err_reg, err_next;
    logic                  result_valid_reg;
    bbc_pkg::result_item_t result_data_reg, result_data_next;
    bbc_pkg::stack_ctl_t   ctl;
    bbc_pkg::opener_t      op, cl, top;
    bbc_pkg::status_t      status;
    logic                  char_acc;
    logic                  line_end;
    logic                  err_held;

    // Accept whenever the output register is free or being drained
    assign char_stall = result_valid_reg && result_stall;
    assign char_acc   = char_valid && !char_stall;

    assign op = bbc_pkg::opener_of(char_data.char_code);
    assign cl = bbc_pkg::closer_of(char_data.char_code);

    // Examine the character unless an error is already held
    always_comb
    begin
        err_next   = err_reg;
        depth_next = depth_reg;
        ctl.push   = 1'b0;
        ctl.pop    = 1'b0;
        if (err_reg == bbc_pkg::ST_OK)
        begin
            priority if (!bbc_pkg::char_allowed(char_data.char_code))
            begin
                err_next = bbc_pkg::ST_BADCHAR;
            end
            else if (op != bbc_pkg::NO_OPENER)
            begin
                if (depth_reg == FULL_DEPTH)
                begin
                    err_next = bbc_pkg::ST_OVERFLOW;
                end
                else
                begin
                    ctl.push   = char_acc;
                    depth_next = depth_reg + 1'b1;
                end
            end
            else if (cl != bbc_pkg::NO_OPENER)
            begin
                if (depth_reg == '0)
                begin
                    err_next = bbc_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    ctl.pop    = char_acc;
                    depth_next = depth_reg - 1'b1;
                    if (top != cl)
                    begin
                        err_next = bbc_pkg::ST_MISMATCH;
                    end
                end
            end
            else
            begin
                // plain characters leave depth and error unchanged
                err_next = err_reg;
            end
        end
    end

    // Form each result, with the line verdict on the last character
    always_comb
    begin
        status = err_next;
        if (char_data.is_last && err_next == bbc_pkg::ST_OK)
        begin
            status = (depth_next != '0) ? bbc_pkg::ST_UNCLOSED : bbc_pkg::ST_VALID;
        end
        result_data_next.status     = status;
        result_data_next.line_done  = char_data.is_last;
        result_data_next.nest_depth = bbc_pkg::nest_of(depth_next);
    end

    bbc_stack u_stack (
        .clk       (clk),
        .ctl       (ctl),
        .push_code (op),
        .top       (top)
    );

    // Advance depth and error on each accepted character; clear both at the end of a line; track result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= '0;
            err_reg          <= bbc_pkg::ST_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_acc)
            begin
                if (char_data.is_last)
                begin
                    depth_reg <= '0;
                    err_reg   <= bbc_pkg::ST_OK;
                end
                else
                begin
                    depth_reg <= depth_next;
                    err_reg   <= err_next;
                end
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register on each transaction
    always_ff @(posedge clk)
    begin
        if (char_acc)
        begin
            result_data_reg <= result_data_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // Qualify line ends and held errors for the checks
    assign line_end = char_acc && char_data.is_last;
    assign err_held = (err_reg != bbc_pkg::ST_OK) && !line_end;

    `BBC_ASSERT_IMPL(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= FULL_DEPTH)
    `BBC_ASSERT_NEXT(a_line_clear, clk, rst_n, line_end, depth_reg == '0 && err_reg == bbc_pkg::ST_OK)
    `BBC_ASSERT_NEXT(a_err_sticky, clk, rst_n, err_held, err_reg == $past(err_reg))
    `BBC_ASSERT_NEXT(a_depth_frozen, clk, rst_n, err_held, depth_reg == $past(depth_reg))
    `BBC_ASSERT_IMPL(a_one_shift, clk, rst_n, 1'b1, !(ctl.push && ctl.pop))

endmodule

@@ hw/rtl/bbc_cell.sv @@
// One stack cell: holds one opener code and shifts with its neighbors.
module bbc_cell (
    input  logic                clk,
    input  bbc_pkg::stack_ctl_t ctl,
    input  bbc_pkg::opener_t    above,
    input  bbc_pkg::opener_t    below,
    output bbc_pkg::opener_t    entry
);

    bbc_pkg::opener_t entry_reg;

    // Shift down on push, up on pop, else hold
    always_ff @(posedge clk)
    begin
        priority if (ctl.push)
        begin
            entry_reg <= above;
        end
        else if (ctl.pop)
        begin
            entry_reg <= below;
        end
        else
        begin
            entry_reg <= entry_reg;
        end
    end

    assign entry = entry_reg;

endmodule

@@ hw/rtl/bbc_stack.sv @@
// Opener stack built as a chain of shifting cells; cell 0 is the top.
module bbc_stack (
    input  logic                clk,
    input  bbc_pkg::stack_ctl_t ctl,
    input  bbc_pkg::opener_t    push_code,
    output bbc_pkg::opener_t    top
);

    bbc_pkg::opener_t cell_q [bbc_pkg::STACK_DEPTH];

    // Wire each cell to its upper and lower neighbor
    for (genvar i = 0; i < bbc_pkg::STACK_DEPTH; i++)
    begin : g_cell
        bbc_pkg::opener_t above;
        bbc_pkg::opener_t below;

        if (i == 0)
        begin : g_head
            assign above = push_code;
        end
        else
        begin : g_mid_a
            assign above = cell_q[i-1];
        end

        if (i == bbc_pkg::STACK_DEPTH - 1)
        begin : g_tail
            assign below = bbc_pkg::OPEN_SQUARE;
        end
        else
        begin : g_mid_b
            assign below = cell_q[i+1];
        end

        bbc_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .above (above),
            .below (below),
            .entry (cell_q[i])
        );
    end

    assign top = cell_q[0];

endmodule
